FILE: sv/u8css_pkg.sv
// Shared types and code point constants for the UTF-8 CSS input decoder.
package u8css_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [30:0] CP_LF   = 31'h0000000A;
	localparam logic [30:0] CP_FF   = 31'h0000000C;
	localparam logic [30:0] CP_CR   = 31'h0000000D;
	localparam logic [30:0] CP_REPL = 31'h0000FFFD;

	// Work for one input byte, in the fixed order the results leave:
	// flushed LF, error mark, replayed continuation bytes, decoded point,
	// second error mark, final LF.
	typedef struct packed {
		logic        lf_first;
		logic        err_first;
		logic [2:0]  rep_n;
		logic [23:0] rep_bits;
		logic        pt_valid;
		logic [30:0] pt_val;
		logic        err_second;
		logic        lf_last;
	} job_t;

endpackage

FILE: sv/u8css_front.sv
// Front end: decodes one byte a cycle while accept is high and classifies it into a result job.
module u8css_front import u8css_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_buffer,
	output job_t       job,
	output logic       job_valid
);

	typedef struct packed {
		logic        lf;
		logic        valid;
		logic [30:0] val;
		logic        crp;
	} point_t;

	logic [30:0] acc_q, acc_n, acc_cont;
	logic [2:0]  exp_q, exp_n;
	logic [2:0]  tak_q, tak_n, tak_inc;
	logic        crp_q, crp;
	point_t      pr;

	// Preprocess one finished code point against a pending CR.
	function automatic point_t point(input logic crp_in, input logic [30:0] cp);
		point_t r;
		r = '0;
		if (crp_in) begin
			r.lf = 1'b1;
		end
		if (crp_in && cp == CP_LF) begin
			r.valid = 1'b0;
		end else if (cp == 31'd0) begin
			r.valid = 1'b1;
			r.val   = CP_REPL;
		end else if (cp == CP_FF) begin
			r.valid = 1'b1;
			r.val   = CP_LF;
		end else if (cp == CP_CR) begin
			r.crp = 1'b1;
		end else begin
			r.valid = 1'b1;
			r.val   = cp;
		end
		return r;
	endfunction

	always_comb begin
		job      = '0;
		crp      = crp_q;
		acc_n    = acc_q;
		exp_n    = exp_q;
		tak_n    = tak_q;
		pr       = '0;
		acc_cont = {acc_q[24:0], in_byte[5:0]};
		tak_inc  = tak_q + 3'd1;
		if (exp_q != 3'd0 && in_byte[7:6] == 2'b10) begin
			acc_n = acc_cont;
			tak_n = tak_inc;
			if (tak_inc >= exp_q) begin
				pr           = point(crp, acc_cont);
				job.lf_first = pr.lf;
				job.pt_valid = pr.valid;
				job.pt_val   = pr.val;
				crp          = pr.crp;
				acc_n        = '0;
				exp_n        = 3'd0;
				tak_n        = 3'd0;
			end
		end else begin
			if (exp_q != 3'd0) begin
				// broken sequence: flag it, replay what was taken
				job.lf_first  = crp;
				crp           = 1'b0;
				job.err_first = 1'b1;
				job.rep_n     = tak_q;
				job.rep_bits  = acc_q[23:0];
				acc_n         = '0;
				exp_n         = 3'd0;
				tak_n         = 3'd0;
			end
			priority if (in_byte < 8'hC0) begin
				pr           = point(crp, {23'd0, in_byte});
				job.lf_first = job.lf_first | pr.lf;
				job.pt_valid = pr.valid;
				job.pt_val   = pr.val;
				crp          = pr.crp;
			end else if (in_byte < 8'hE0) begin
				acc_n = {26'd0, in_byte[4:0]};
				exp_n = 3'd1;
				tak_n = 3'd0;
			end else if (in_byte < 8'hF0) begin
				acc_n = {27'd0, in_byte[3:0]};
				exp_n = 3'd2;
				tak_n = 3'd0;
			end else if (in_byte < 8'hF8) begin
				acc_n = {28'd0, in_byte[2:0]};
				exp_n = 3'd3;
				tak_n = 3'd0;
			end else if (in_byte < 8'hFC) begin
				acc_n = {29'd0, in_byte[1:0]};
				exp_n = 3'd4;
				tak_n = 3'd0;
			end else if (in_byte < 8'hFE) begin
				acc_n = {30'd0, in_byte[0]};
				exp_n = 3'd5;
				tak_n = 3'd0;
			end else begin
				acc_n          = '0;
				exp_n          = 3'd0;
				tak_n          = 3'd0;
				job.lf_first   = job.lf_first | crp;
				crp            = 1'b0;
				job.err_second = 1'b1;
			end
		end
		if (end_of_buffer) begin
			if (exp_n != 3'd0) begin
				if (job.err_first) begin
					job.err_second = 1'b1;
				end else begin
					job.lf_first  = job.lf_first | crp;
					crp           = 1'b0;
					job.err_first = 1'b1;
					job.rep_n     = tak_n;
					job.rep_bits  = acc_n[23:0];
				end
			end
			if (crp) begin
				job.lf_last = 1'b1;
				crp         = 1'b0;
			end
			acc_n = '0;
			exp_n = 3'd0;
			tak_n = 3'd0;
		end
		job_valid = job.lf_first | job.err_first | (job.rep_n != 3'd0) | job.pt_valid
			| job.err_second | job.lf_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			exp_q <= 3'd0;
			tak_q <= 3'd0;
			crp_q <= 1'b0;
		end else if (accept) begin
			acc_q <= acc_n;
			exp_q <= exp_n;
			tak_q <= tak_n;
			crp_q <= crp;
		end
	end

endmodule

FILE: sv/u8css_queue.sv
// Short job queue between the decoder front end and the result expander.
module u8css_queue import u8css_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/u8css_back.sv
// Back end: expands the head job into results in an output register, one per cycle unless it is stalled.
module u8css_back import u8css_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_empty,
	output logic        job_pop,
	input  logic        pop,
	output logic        empty,
	output logic [30:0] code_point,
	output logic        replaced,
	output logic        last_of_run
);

	logic        out_valid_q;
	logic [30:0] cp_q;
	logic        rep_q, last_q;
	logic        done_a_q, done_b_q, done_d_q, done_e_q;
	logic [2:0]  rep_cnt_q;

	logic        pa, pb, pr, pd, pe, pf;
	logic        load, emit;
	logic [30:0] nx_cp;
	logic        nx_rep, nx_last, rep_end;
	logic [2:0]  grp_full;
	logic [1:0]  grp;
	logic [5:0]  rep_six;
	logic [2:0]  sel;

	localparam logic [2:0] SEL_A = 3'd0;
	localparam logic [2:0] SEL_B = 3'd1;
	localparam logic [2:0] SEL_R = 3'd2;
	localparam logic [2:0] SEL_D = 3'd3;
	localparam logic [2:0] SEL_E = 3'd4;
	localparam logic [2:0] SEL_F = 3'd5;

	assign load = !out_valid_q || pop;
	assign emit = load && !job_empty;

	assign pa = job.lf_first & !done_a_q;
	assign pb = job.err_first & !done_b_q;
	assign pr = rep_cnt_q < job.rep_n;
	assign pd = job.pt_valid & !done_d_q;
	assign pe = job.err_second & !done_e_q;
	assign pf = job.lf_last;

	// First taken continuation byte is the most significant group.
	assign grp_full = job.rep_n - 3'd1 - rep_cnt_q;
	assign grp      = grp_full[1:0];
	assign rep_end  = (rep_cnt_q + 3'd1) >= job.rep_n;

	always_comb begin
		unique case (grp)
			2'd0: rep_six = job.rep_bits[5:0];
			2'd1: rep_six = job.rep_bits[11:6];
			2'd2: rep_six = job.rep_bits[17:12];
			default: rep_six = job.rep_bits[23:18];
		endcase
	end

	always_comb begin
		priority if (pa) begin
			sel     = SEL_A;
			nx_cp   = CP_LF;
			nx_rep  = 1'b0;
			nx_last = !(pb | pr | pd | pe | pf);
		end else if (pb) begin
			sel     = SEL_B;
			nx_cp   = CP_REPL;
			nx_rep  = 1'b1;
			nx_last = !(pr | pd | pe | pf);
		end else if (pr) begin
			sel     = SEL_R;
			nx_cp   = {23'd0, 2'b10, rep_six};
			nx_rep  = 1'b0;
			nx_last = rep_end & !(pd | pe | pf);
		end else if (pd) begin
			sel     = SEL_D;
			nx_cp   = job.pt_val;
			nx_rep  = 1'b0;
			nx_last = !(pe | pf);
		end else if (pe) begin
			sel     = SEL_E;
			nx_cp   = CP_REPL;
			nx_rep  = 1'b1;
			nx_last = !pf;
		end else begin
			sel     = SEL_F;
			nx_cp   = CP_LF;
			nx_rep  = 1'b0;
			nx_last = 1'b1;
		end
	end

	assign job_pop = emit && nx_last;

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q   <= nx_cp;
			rep_q  <= nx_rep;
			last_q <= nx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_a_q    <= 1'b0;
			done_b_q    <= 1'b0;
			done_d_q    <= 1'b0;
			done_e_q    <= 1'b0;
			rep_cnt_q   <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= !job_empty;
			end
			if (emit) begin
				if (nx_last) begin
					done_a_q  <= 1'b0;
					done_b_q  <= 1'b0;
					done_d_q  <= 1'b0;
					done_e_q  <= 1'b0;
					rep_cnt_q <= 3'd0;
				end else begin
					unique case (sel)
						SEL_A: done_a_q <= 1'b1;
						SEL_B: done_b_q <= 1'b1;
						SEL_R: rep_cnt_q <= rep_cnt_q + 3'd1;
						SEL_D: done_d_q <= 1'b1;
						SEL_E: done_e_q <= 1'b1;
						default: done_e_q <= done_e_q;
					endcase
				end
			end
		end
	end

	assign empty       = !out_valid_q;
	assign code_point  = cp_q;
	assign replaced    = rep_q;
	assign last_of_run = last_q;

endmodule

FILE: sv/utf8_css_input_decoder.sv
// Top level of the UTF-8 decoder with CSS input preprocessing.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  byte in   | push / full        | in_byte[7:0], end_of_buffer
//  result out| pop / empty        | code_point[30:0], replaced, last_of_run
//
// One byte is taken per cycle while the job queue has room. Each byte yields
// 0 to 7 results, delivered one per cycle while the output is not stalled; a byte
// with no result skips the queue. Replay bursts drain through the DEPTH-entry job
// queue. Each result passes through its job queue entry and then the output register.
// Reset clears the decoder state, the queue pointers and count, and the output valid flag.
// full rises only when the job queue is full; a stalled output holds its result.
module utf8_css_input_decoder import u8css_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [30:0] code_point,
	output logic        replaced,
	output logic        last_of_run
);

	logic accept;
	job_t fr_job;
	logic fr_valid;
	job_t hd_job;
	logic q_empty;
	logic q_pop;

	// Take a byte on every push transaction the queue has room for.
	assign accept = push && !full;

	u8css_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.job           (fr_job),
		.job_valid     (fr_valid)
	);

	// Drop bytes that give no result; only real jobs enter the queue.
	u8css_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && fr_valid),
		.wr_job (fr_job),
		.full   (full),
		.rd_en  (q_pop),
		.rd_job (hd_job),
		.empty  (q_empty)
	);

	// Advance through the head job, one result per pop transaction.
	u8css_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (hd_job),
		.job_empty   (q_empty),
		.job_pop     (q_pop),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.replaced    (replaced),
		.last_of_run (last_of_run)
	);

endmodule
